FILE: rtl/brb_pkg.sv
package brb_pkg;

    // Command codes carried in s_tuser
    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_FORCE  = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    // Result status carried in m_tuser
    localparam logic STAT_DONE    = 1'b0;
    localparam logic STAT_REFUSED = 1'b1;

    // Fixed item geometry
    localparam int MAX_BYTES = 8;
    localparam int LEN_W     = 4;
    localparam int CAP_W     = 11;
    localparam int CMD_W     = 2;
    localparam int DATA_W    = 72;

    typedef logic [7:0]       byte_t;
    typedef logic [LEN_W-1:0] len_t;
    typedef logic [CAP_W-1:0] cap_t;
    typedef logic [CMD_W-1:0] cmd_t;

endpackage

FILE: rtl/byte_ring_buffer_overwrite.sv
// Circular byte queue with optional overwrite. Each input item carries a command in
// s_tuser (write, forced write, read, clear) and a length plus up to eight bytes in
// s_tdata; each item gives exactly one result with a refused flag in m_tuser and the
// byte count plus read bytes in m_tdata. Bytes live in one RING_DEPTH x 8 memory with
// a registered read, and the ring uses the first "capacity" entries, of which
// capacity-1 can hold data; writing the capacity register also empties the queue.
// Items are handled one at a time; the memory moves one byte per cycle while an item
// moves bytes. An item is decided in S_DECIDE, moves bytes in S_WRITE or S_READ (a
// read also waits for the registered read data), then loads the result register in
// S_DONE once the output is free; clear, refusal or empty moves skip the byte states.
// A finished result waits in the output register while the next item is taken in.
module byte_ring_buffer_overwrite #(
    parameter int RING_DEPTH = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration: capacity
    input  logic                        cfg_we,
    input  brb_pkg::cap_t               cfg_wdata,
    // input items
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  brb_pkg::cmd_t               s_tuser,   // [1:0] command
    input  logic [brb_pkg::DATA_W-1:0]  s_tdata,   // [3:0] length, [11:4] byte_in_0 .. [67:60] byte_in_7
    // result items
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [0:0]                  m_tuser,   // [0] status
    output logic [brb_pkg::DATA_W-1:0]  m_tdata    // [3:0] moved, [11:4] byte_out_0 .. [67:60] byte_out_7
);
    import brb_pkg::*;

    localparam int PTR_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW      = (PTR_W + 1 > CAP_W) ? PTR_W + 1 : CAP_W;
    localparam int CAP_RST = (RING_DEPTH < 1024) ? RING_DEPTH : 1024;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_WRITE  = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    // ring memory
    byte_t mem [RING_DEPTH];
    byte_t rdata_reg;

    logic [2:0]       state_reg;
    cmd_t             cmd_reg;
    len_t             len_reg;
    byte_t            byte_q_reg [MAX_BYTES];
    byte_t            obyte_reg  [MAX_BYTES];
    logic [PTR_W-1:0] wp_reg;
    logic [PTR_W-1:0] rp_reg;
    logic [PTR_W-1:0] p_reg;
    len_t             cnt_reg;
    len_t             capt_reg;
    len_t             num_reg;
    logic             status_reg;
    logic             rvalid_reg;
    logic [CW-1:0]    cap_reg;

    logic                m_tvalid_reg;
    logic [0:0]          m_tuser_reg;
    logic [DATA_W-1:0]   m_tdata_reg;

    // decision datapath
    len_t             len_clip;
    logic [CW-1:0]    len_ext;
    logic [CW-1:0]    used;
    logic [CW-1:0]    room;
    logic [CW-1:0]    drop;
    logic [CW-1:0]    rp_sum;
    logic [PTR_W-1:0] rp_dropped;
    len_t             n_read;
    logic             oversize;
    logic             short_room;
    logic [PTR_W-1:0] p_adv;
    logic             rd_issue;
    logic             wr_en;
    logic             out_free;
    logic [CW-1:0]    cfg_cap;
    logic [DATA_W-1:0] out_data;

    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;

    // clamp the written capacity into 2 .. RING_DEPTH
    always_comb
    begin
        priority if (cfg_wdata < CAP_W'(2))
            cfg_cap = CW'(2);
        else if (CW'(cfg_wdata) > CW'(RING_DEPTH))
            cfg_cap = CW'(RING_DEPTH);
        else
            cfg_cap = CW'(cfg_wdata);
    end

    // occupancy, room and the forced-write drop
    always_comb
    begin
        len_clip   = (len_reg > LEN_W'(MAX_BYTES)) ? LEN_W'(MAX_BYTES) : len_reg;
        len_ext    = CW'(len_reg);
        used       = (wp_reg >= rp_reg) ? CW'(wp_reg) - CW'(rp_reg)
                                        : cap_reg - CW'(rp_reg) + CW'(wp_reg);
        room       = cap_reg - CW'(1) - used;
        oversize   = (len_reg > LEN_W'(MAX_BYTES)) || (len_ext > cap_reg - CW'(1));
        short_room = room < len_ext;
        drop       = len_ext - room;
        rp_sum     = CW'(rp_reg) + drop;
        rp_dropped = (rp_sum >= cap_reg) ? PTR_W'(rp_sum - cap_reg) : PTR_W'(rp_sum);
        n_read     = (used < CW'(len_clip)) ? LEN_W'(used) : len_clip;
    end

    // walking pointer step, wrapping at capacity
    assign p_adv    = (CW'(p_reg) + CW'(1) >= cap_reg) ? '0 : p_reg + PTR_W'(1);
    assign rd_issue = (state_reg == S_READ) && (cnt_reg < num_reg);
    assign wr_en    = (state_reg == S_WRITE);

    // memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[p_reg] <= byte_q_reg[0];
        end
        rdata_reg <= mem[p_reg];
    end

    // item payload, not reset
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cmd_reg <= s_tuser;
            len_reg <= s_tdata[LEN_W-1:0];
            for (int k = 0; k < MAX_BYTES; k++)
            begin
                byte_q_reg[k] <= s_tdata[LEN_W + 8*k +: 8];
            end
        end
        else if (wr_en)
        begin
            for (int k = 0; k < MAX_BYTES - 1; k++)
            begin
                byte_q_reg[k] <= byte_q_reg[k+1];
            end
            byte_q_reg[MAX_BYTES-1] <= '0;
        end

        if (state_reg == S_DECIDE)
        begin
            for (int k = 0; k < MAX_BYTES; k++)
            begin
                obyte_reg[k] <= '0;
            end
        end
        else if (rvalid_reg)
        begin
            obyte_reg[capt_reg[2:0]] <= rdata_reg;
        end
    end

    // sequencer and pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            wp_reg     <= '0;
            rp_reg     <= '0;
            p_reg      <= '0;
            cnt_reg    <= '0;
            capt_reg   <= '0;
            num_reg    <= '0;
            status_reg <= STAT_DONE;
            rvalid_reg <= 1'b0;
            cap_reg    <= CW'(CAP_RST);
        end
        else
        begin
            rvalid_reg <= rd_issue;
            if (cfg_we)
            begin
                cap_reg <= cfg_cap;
                wp_reg  <= '0;
                rp_reg  <= '0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    cnt_reg    <= '0;
                    capt_reg   <= '0;
                    status_reg <= STAT_DONE;
                    unique case (cmd_reg)
                        CMD_CLEAR:
                        begin
                            wp_reg    <= '0;
                            rp_reg    <= '0;
                            num_reg   <= '0;
                            state_reg <= S_DONE;
                        end
                        CMD_READ:
                        begin
                            num_reg   <= n_read;
                            p_reg     <= rp_reg;
                            state_reg <= (n_read == '0) ? S_DONE : S_READ;
                        end
                        CMD_WRITE, CMD_FORCE:
                        begin
                            if (oversize || (short_room && cmd_reg == CMD_WRITE))
                            begin
                                status_reg <= STAT_REFUSED;
                                num_reg    <= '0;
                                state_reg  <= S_DONE;
                            end
                            else
                            begin
                                if (short_room)
                                begin
                                    rp_reg <= rp_dropped;
                                end
                                num_reg   <= len_reg;
                                p_reg     <= wp_reg;
                                state_reg <= (len_reg == '0) ? S_DONE : S_WRITE;
                            end
                        end
                        default:
                        begin
                            state_reg <= S_DONE;
                        end
                    endcase
                end
                S_READ:
                begin
                    if (rd_issue)
                    begin
                        p_reg   <= p_adv;
                        cnt_reg <= cnt_reg + LEN_W'(1);
                    end
                    if (rvalid_reg)
                    begin
                        capt_reg <= capt_reg + LEN_W'(1);
                        if (capt_reg + LEN_W'(1) == num_reg)
                        begin
                            rp_reg    <= p_reg;
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_WRITE:
                begin
                    p_reg   <= p_adv;
                    cnt_reg <= cnt_reg + LEN_W'(1);
                    if (cnt_reg + LEN_W'(1) == num_reg)
                    begin
                        wp_reg    <= p_adv;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // pack the result
    always_comb
    begin
        out_data = '0;
        out_data[LEN_W-1:0] = num_reg;
        for (int k = 0; k < MAX_BYTES; k++)
        begin
            out_data[LEN_W + 8*k +: 8] = obyte_reg[k];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (state_reg == S_DONE && out_free)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && out_free)
        begin
            m_tuser_reg <= status_reg;
            m_tdata_reg <= out_data;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

    // pointers stay inside the ring in use
    assert property (@(posedge clk) disable iff (!rst_n)
        (CW'(wp_reg) < cap_reg) && (CW'(rp_reg) < cap_reg))
        else $error("ring pointer beyond capacity");

    // a refused item moves nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0] == STAT_REFUSED) |-> (m_tdata[LEN_W-1:0] == '0))
        else $error("refused item reports moved bytes");

    // never more bytes than an item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[LEN_W-1:0] <= LEN_W'(MAX_BYTES)))
        else $error("moved count too large");

    // read data is captured only while reading
    assert property (@(posedge clk) disable iff (!rst_n)
        rvalid_reg |-> (state_reg == S_READ))
        else $error("read data outside read sequence");

endmodule

FILE: test/byte_ring_buffer_overwrite_checker.sv
`timescale 1ns / 100ps

// Watches the config port and both item channels, keeps its own copy of the ring,
// predicts one result per accepted input item and compares field by field.
module byte_ring_buffer_overwrite_checker
    import brb_pkg::*;
#(
    parameter int RING_DEPTH = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  cap_t              cfg_wdata,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  cmd_t              s_tuser,
    input  logic [DATA_W-1:0] s_tdata,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [0:0]        m_tuser,
    input  logic [DATA_W-1:0] m_tdata,
    output int                mismatches,
    output int                results_pending
);

    typedef struct packed {
        logic                        status;
        len_t                        moved;
        logic [MAX_BYTES-1:0][7:0]   data;
    } ring_result_t;

    // shadow ring state
    byte_t        ring_bytes [RING_DEPTH];
    int unsigned  wr_ptr;
    int unsigned  rd_ptr;
    cap_t         capacity_reg;
    ring_result_t pending_results [$];

    // ring size in use, with the register clamped into 2..RING_DEPTH
    function automatic int unsigned ring_size();
        int unsigned c;
        c = capacity_reg;
        if (c < 2)
            c = 2;
        if (c > RING_DEPTH)
            c = RING_DEPTH;
        return c;
    endfunction

    function automatic int unsigned step_ptr(input int unsigned p, input int unsigned n,
                                             input int unsigned c);
        p = p + n;
        if (p >= c)
            p = p - c;
        return p;
    endfunction

    // apply one command to the shadow ring and return the result it should give
    function automatic ring_result_t run_command(input cmd_t cmd, input len_t len,
                                                 input logic [8*MAX_BYTES-1:0] payload);
        ring_result_t res;
        int unsigned  c;
        int unsigned  n;
        int unsigned  want;
        int unsigned  room;
        int unsigned  p;
        res = '0;
        c = ring_size();
        if (wr_ptr >= c)
            wr_ptr = 0;
        if (rd_ptr >= c)
            rd_ptr = 0;
        case (cmd)
            CMD_CLEAR:
            begin
                wr_ptr = 0;
                rd_ptr = 0;
            end
            CMD_READ:
            begin
                want = (len > MAX_BYTES) ? MAX_BYTES : len;
                n = (rd_ptr <= wr_ptr) ? wr_ptr - rd_ptr : c - rd_ptr + wr_ptr;
                if (n > want)
                    n = want;
                p = rd_ptr;
                for (int i = 0; i < n; i++)
                begin
                    res.data[i] = ring_bytes[p];
                    p = step_ptr(p, 1, c);
                end
                rd_ptr = p;
                res.moved = len_t'(n);
            end
            default:
            begin
                // write or forced write
                room = (wr_ptr < rd_ptr) ? rd_ptr - wr_ptr - 1 : c - wr_ptr + rd_ptr - 1;
                if (len > MAX_BYTES || len > c - 1)
                    res.status = STAT_REFUSED;
                else if (room < len && cmd == CMD_WRITE)
                    res.status = STAT_REFUSED;
                else
                begin
                    // forced write drops the oldest bytes first
                    if (room < len)
                        rd_ptr = step_ptr(rd_ptr, len - room, c);
                    p = wr_ptr;
                    for (int i = 0; i < len; i++)
                    begin
                        ring_bytes[p] = payload[8*i +: 8];
                        p = step_ptr(p, 1, c);
                    end
                    wr_ptr = p;
                    res.moved = len;
                end
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: %s", $time, what);
        mismatches = mismatches + 1;
    endtask

    // track config writes, check results, predict new items
    always @(posedge clk or negedge rst_n)
    begin : track
        ring_result_t oldest;
        if (!rst_n)
        begin
            wr_ptr = 0;
            rd_ptr = 0;
            capacity_reg = 11'd1024;
            pending_results.delete();
            mismatches = 0;
            results_pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg = cfg_wdata;
                wr_ptr = 0;
                rd_ptr = 0;
            end
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch($sformatf("result item with none pending, moved %0d",
                                              m_tdata[3:0]));
                else
                begin
                    oldest = pending_results.pop_front();
                    if (m_tuser[0] !== oldest.status)
                        report_mismatch($sformatf("status got %0d expected %0d",
                                                  m_tuser[0], oldest.status));
                    if (m_tdata[3:0] !== oldest.moved)
                        report_mismatch($sformatf("moved got %0d expected %0d",
                                                  m_tdata[3:0], oldest.moved));
                    for (int k = 0; k < MAX_BYTES; k++)
                    begin
                        if (m_tdata[4 + 8*k +: 8] !== oldest.data[k])
                            report_mismatch($sformatf("byte_out_%0d got %0h expected %0h",
                                                      k, m_tdata[4 + 8*k +: 8],
                                                      oldest.data[k]));
                    end
                end
            end
            if (s_tvalid && s_tready)
                pending_results.push_back(run_command(s_tuser, s_tdata[3:0],
                                                      s_tdata[4 +: 8*MAX_BYTES]));
            results_pending = pending_results.size();
        end
    end

endmodule

FILE: test/byte_ring_buffer_overwrite_tb.sv
`timescale 1ns / 100ps

module byte_ring_buffer_overwrite_tb;
    import brb_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 40;
    localparam int HOLD_CYCLES = 300;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    cap_t              cfg_wdata = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    cmd_t              s_tuser   = CMD_WRITE;
    logic [DATA_W-1:0] s_tdata   = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [0:0]        m_tuser;
    logic [DATA_W-1:0] m_tdata;

    int mismatches;
    int results_pending;
    int send_idle    = 0;
    int recv_idle    = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;

    always #5 clk = ~clk;

    byte_ring_buffer_overwrite dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata)
    );

    byte_ring_buffer_overwrite_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tuser         (s_tuser),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tuser         (m_tuser),
        .m_tdata         (m_tdata),
        .mismatches      (mismatches),
        .results_pending (results_pending)
    );

    // result side: random stalls, or a long hold-off when requested
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left = hold_left - 1;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // watchdog: too long without any item moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles = quiet_cycles + 1;
                if (quiet_cycles >= STALL_LIMIT)
                begin
                    $display("Mismatches found");
                    $finish;
                end
            end
        end
    end

    // offer one item, with random gaps ahead of it; returns at a falling edge
    task automatic send_item(input cmd_t cmd, input len_t len, input logic [63:0] payload);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tuser  <= cmd;
        s_tdata  <= {4'b0, payload, len};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // stop offering and wait for every predicted result to come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (results_pending != 0)
            @(negedge clk);
    endtask

    task automatic write_capacity(input cap_t value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // mostly well-formed commands; some oversize lengths and rare clears
    task automatic send_random(input int read_pct, input int clear_pct);
        int   pick;
        cmd_t cmd;
        len_t len;
        pick = $urandom_range(99);
        if (pick < clear_pct)
            cmd = CMD_CLEAR;
        else if (pick < clear_pct + read_pct)
            cmd = CMD_READ;
        else if ($urandom_range(99) < 60)
            cmd = CMD_WRITE;
        else
            cmd = CMD_FORCE;
        if ($urandom_range(9) == 0)
            len = len_t'($urandom_range(15, 9));
        else
            len = len_t'($urandom_range(8));
        send_item(cmd, len, {$urandom, $urandom});
    endtask

    task automatic run_segment(input cap_t cap, input int read_pct, input int clear_pct,
                               input int count, input int hold_at, input int pause_at);
        write_capacity(cap);
        for (int i = 0; i < count; i++)
        begin
            if (i == hold_at)
                hold_left = HOLD_CYCLES;
            if (i == pause_at)
                drain_results();
            send_random(read_pct, clear_pct);
        end
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty read, zero and full writes, oversize lengths
        send_item(CMD_READ,  4'd8,  64'h0);
        send_item(CMD_WRITE, 4'd0,  64'hFFFF_FFFF_FFFF_FFFF);
        send_item(CMD_WRITE, 4'd8,  64'hFF00_FF00_A55A_00FF);
        send_item(CMD_WRITE, 4'd9,  64'h1234_5678_9ABC_DEF0);
        send_item(CMD_FORCE, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(CMD_READ,  4'd15, 64'h0);
        send_item(CMD_WRITE, 4'd5,  {$urandom, $urandom});
        send_item(CMD_READ,  4'd3,  64'h0);
        send_item(CMD_READ,  4'd8,  64'h0);
        send_item(CMD_WRITE, 4'd4,  {$urandom, $urandom});
        send_item(CMD_CLEAR, 4'd4,  64'h0);
        send_item(CMD_READ,  4'd4,  64'h0);

        // smallest ring: full, refused, overwrite, oversize for the ring
        write_capacity(11'd2);
        send_item(CMD_WRITE, 4'd1,  64'h00AA);
        send_item(CMD_WRITE, 4'd1,  64'h00BB);
        send_item(CMD_FORCE, 4'd1,  64'h00CC);
        send_item(CMD_FORCE, 4'd2,  64'hDDEE);
        send_item(CMD_READ,  4'd8,  64'h0);
        send_item(CMD_WRITE, 4'd1,  64'h0011);

        // register write empties the queue; below-range capacity
        write_capacity(11'd0);
        send_item(CMD_READ,  4'd2,  64'h0);
        send_item(CMD_FORCE, 4'd1,  64'h0022);
        send_item(CMD_READ,  4'd2,  64'h0);

        // above-range capacity, then a wrap with overwrite
        write_capacity(11'd2047);
        send_item(CMD_WRITE, 4'd8,  {$urandom, $urandom});
        send_item(CMD_READ,  4'd8,  64'h0);
        write_capacity(11'd5);
        send_item(CMD_WRITE, 4'd3,  {$urandom, $urandom});
        send_item(CMD_FORCE, 4'd4,  {$urandom, $urandom});
        send_item(CMD_READ,  4'd8,  64'h0);

        // random: sender rarely idle, receiver mostly stalled
        send_idle = 12;
        recv_idle = 77;
        run_segment(11'd2047, 10, 0, 450, 100, -1);
        run_segment(11'd2, 30, 3, 150, -1, -1);
        run_segment(11'd9, 35, 2, 200, -1, -1);

        // sender mostly idle, receiver rarely stalled
        send_idle = 77;
        recv_idle = 12;
        run_segment(cap_t'($urandom_range(300, 10)), 25, 1, 300, -1, 150);
        run_segment(11'd0, 40, 3, 100, -1, -1);
        run_segment(11'd1024, 20, 0, 200, -1, -1);

        // no idling on either side
        send_idle = 0;
        recv_idle = 0;
        run_segment(11'd1, 35, 2, 100, -1, -1);
        run_segment(cap_t'($urandom_range(2047)), 30, 1, 250, 120, -1);
        run_segment(11'd17, 40, 2, 150, -1, -1);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && results_pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
